[hdl/sbdtr_pkg.sv]
// Shared types, constants and helpers for the SBUS decode and telemetry reframe unit.
`timescale 1ns / 1ps
`default_nettype none
package sbdtr_pkg;

  localparam int NUM_CH    = 16;
  localparam int RAW_W     = 11;
  localparam int PW_W      = 12;
  localparam int DATA_BITS = NUM_CH * RAW_W;
  localparam int TEL_LEN   = 24;
  localparam int NUM_DATA  = 12;

  localparam logic [7:0]  SYNC_BYTE   = 8'h0F;
  localparam logic [7:0]  END_BYTE    = 8'h00;
  localparam logic [15:0] INTERVAL_RST = 16'd66;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  WHITE_EVEN  = 8'hBD;
  localparam logic [7:0]  WHITE_ODD   = 8'hDB;

  // One decoded frame handed from the front to the back.
  typedef struct packed {
    logic [DATA_BITS-1:0] raw_bits;
    logic                 failsafe;
    logic                 tel;
    logic [10:0]          sync;
  } sbdtr_job_t;

  // One result slot moving through the back pipeline.
  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    logic        last;
    logic [10:0] raw;
    logic        failsafe;
    logic [10:0] sync;
  } sbdtr_tok_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h00;
      3'd6:    b = 8'hFE;
      3'd7:    b = 8'h10;
      default: b = 8'hAD;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/sbdtr_front.sv]
// Front end: byte window, frame detection, telemetry interval and sync bookkeeping.
`timescale 1ns / 1ps
`default_nettype none
module sbdtr_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      in_tick,
  input  wire  [7:0]               in_byte,
  input  wire                      cfg_wen,
  input  wire  [15:0]              cfg_wdata,
  output logic                     job_valid,
  input  wire                      job_full,
  output sbdtr_pkg::sbdtr_job_t    job
);
  import sbdtr_pkg::*;

  // win[k] is the window byte k places newer than the oldest slot, win[0].
  logic [7:0]  win [0:23];
  logic [15:0] elapsed;
  logic [10:0] sync;
  logic [15:0] interval;
  logic        acc, frame_hit, fs, send;

  assign in_ready  = !job_full;
  assign acc       = in_valid && in_ready;
  assign frame_hit = acc && !in_tick && (win[0] == SYNC_BYTE) && (in_byte == END_BYTE);
  assign fs        = win[23][3];
  assign send      = !fs && (elapsed >= interval);
  assign job_valid = frame_hit;

  always_comb begin
    for (int j = 0; j < 22; j++) begin
      job.raw_bits[8*j +: 8] = win[j+1];
    end
    job.failsafe = fs;
    job.tel      = send;
    job.sync     = sync + 11'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 24; k++) win[k] <= '0;
      elapsed  <= '0;
      sync     <= '0;
      interval <= INTERVAL_RST;
    end else begin
      if (cfg_wen) interval <= cfg_wdata;
      if (acc && in_tick) begin
        if (elapsed != 16'hFFFF) elapsed <= elapsed + 16'd1;
      end else if (frame_hit) begin
        for (int k = 0; k < 24; k++) win[k] <= '0;
        if (send) begin
          elapsed <= '0;
          sync    <= sync + 11'd1;
        end
      end else if (acc) begin
        for (int k = 0; k < 23; k++) win[k] <= win[k+1];
        win[23] <= in_byte;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/sbdtr_queue.sv]
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sbdtr_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  sbdtr_pkg::sbdtr_job_t push_job,
  output logic                  full,
  input  wire                   pop,
  output logic                  not_empty,
  output sbdtr_pkg::sbdtr_job_t head
);
  import sbdtr_pkg::*;

  sbdtr_job_t  mem [0:1];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

[hdl/sbdtr_back.sv]
// Back end: result sequencing, pulse and quantize pipeline, telemetry framing and CRC.
`timescale 1ns / 1ps
`default_nettype none
module sbdtr_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   job_valid,
  input  sbdtr_pkg::sbdtr_job_t job,
  output logic                  job_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_kind,
  output logic                  out_last,
  output logic [39:0]           out_data
);
  import sbdtr_pkg::*;

  // ceil(2^32 / 1639); exact for every numerator below 4.04e6
  localparam logic [21:0] RECIP = 22'd2620481;

  logic       adv, issue, tok_last;
  logic [5:0] cnt;
  sbdtr_tok_t tok_in;

  // stage A
  logic       va;
  sbdtr_tok_t ta;
  logic       nega;
  logic [21:0] p1, p2;
  // stage B
  logic       vb;
  sbdtr_tok_t tb;
  logic       negb;
  logic [11:0] q1, q2;
  logic [43:0] m1, m2;
  logic [10:0] mag;

  // captured telemetry contents
  logic [10:0] qch [0:3];
  logic [5:0]  q6 [0:5];
  logic        act;
  logic [10:0] tsync;
  logic [7:0]  crc;
  logic [3:0]  crc_idx;
  logic        crc_run;

  logic [95:0] dword;
  logic [7:0]  dw_byte [0:11];
  logic [11:0] pw_c;
  logic [10:0] qv_c;
  logic [5:0]  q6_c;
  logic [7:0]  tx_c;
  logic [3:0]  tel_di;

  assign adv      = !out_valid || out_ready;
  assign tok_last = (cnt == (job.tel ? 6'd39 : 6'd15));
  assign issue    = adv && job_valid;
  assign job_pop  = issue && tok_last;

  always_comb begin
    tok_in.kind     = (cnt >= 6'd16);
    tok_in.idx      = tok_in.kind ? 5'(cnt - 6'd16) : cnt[4:0];
    tok_in.last     = tok_last;
    tok_in.raw      = job.raw_bits[cnt[3:0]*RAW_W +: RAW_W];
    tok_in.failsafe = job.failsafe;
    tok_in.sync     = job.sync;
  end

  assign mag = (tok_in.raw < 11'd172) ? 11'(11'd172 - tok_in.raw) : 11'(tok_in.raw - 11'd172);
  assign m1  = p1 * RECIP;
  assign m2  = p2 * RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      va  <= 1'b0;
      vb  <= 1'b0;
    end else if (adv) begin
      if (issue) cnt <= tok_last ? 6'd0 : cnt + 6'd1;
      va <= issue;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta   <= tok_in;
      nega <= (tok_in.raw < 11'd172);
      p1   <= 22'(mag) * 22'd1000;
      p2   <= 22'(mag) * 22'd2047;
      tb   <= ta;
      negb <= nega;
      q1   <= m1[43:32];
      q2   <= m2[43:32];
    end
  end

  // stage C: pulse width and quantized values
  always_comb begin
    logic [12:0] p;
    p    = negb ? 13'(13'd1000 - 13'(q1)) : 13'(13'd1000 + 13'(q1));
    if (p < 13'd800) p = 13'd800;
    if (p > 13'd2200) p = 13'd2200;
    pw_c = p[11:0];
    qv_c = negb ? 11'd0 : ((q2 > 12'd2047) ? 11'd2047 : q2[10:0]);
    case (tb.idx[3:0])
      4'd5, 4'd6: q6_c = (tb.raw < 11'd600) ? 6'd0 : ((tb.raw > 11'd1400) ? 6'd63 : 6'd31);
      4'd9:       q6_c = (pw_c < 12'd1600) ? 6'd0 : 6'd63;
      default:    q6_c = (tb.raw < 11'd992) ? 6'd0 : 6'd63;
    endcase
  end

  always_comb begin
    dword = {4'd0, act, tsync, q6[5], q6[4], q6[3], q6[2], q6[1], q6[0],
             qch[3], qch[2], qch[1], qch[0]};
    for (int i = 0; i < NUM_DATA; i++) begin
      dw_byte[i] = dword[8*i +: 8] ^ (i[0] ? WHITE_ODD : WHITE_EVEN);
    end
    tel_di = 4'(tb.idx - 5'd9);
    if (tb.idx < 5'd8)       tx_c = hdr_byte(tb.idx[2:0]);
    else if (tb.idx == 5'd8) tx_c = crc;
    else if (tb.idx < 5'd21) tx_c = dw_byte[tel_di];
    else                     tx_c = tb.idx[0] ? WHITE_EVEN : WHITE_ODD;
  end

  // capture per-channel telemetry inputs as channel results retire
  always_ff @(posedge clk) begin
    if (adv && vb && !tb.kind) begin
      if (tb.idx < 5'd4) qch[tb.idx[1:0]] <= qv_c;
      if (tb.idx >= 5'd4 && tb.idx < 5'd10) q6[3'(tb.idx - 5'd4)] <= q6_c;
      if (tb.idx == 5'd4) act <= (tb.raw > 11'd1400);
      if (tb.idx == 5'd0) tsync <= tb.sync;
    end
  end

  // CRC runs one data byte per cycle once the last quantized channel is in
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_run <= 1'b0;
      crc_idx <= '0;
      crc     <= '0;
    end else if (adv && vb && !tb.kind && tb.idx == 5'd9) begin
      crc_run <= 1'b1;
      crc_idx <= '0;
      crc     <= '0;
    end else if (crc_run) begin
      crc     <= crc_step(crc, dw_byte[crc_idx]);
      crc_idx <= crc_idx + 4'd1;
      if (crc_idx == 4'(NUM_DATA - 1)) crc_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind <= tb.kind;
      out_last <= tb.last;
      if (tb.kind) out_data <= {4'd0, tx_c, 28'd0};
      else         out_data <= {12'd0, tb.failsafe, pw_c, tb.raw, tb.idx[3:0]};
    end
  end

endmodule
`default_nettype wire

[hdl/sbus_decode_and_telemetry_reframe_unit.sv]
// SBUS decode and telemetry reframe unit: top level.
// A completing frame byte is pushed into the frame queue; its first channel result then passes
// through stage A, stage B and the output register. Throughput: one result per cycle from the
// back pipeline unless m_axis_tready stalls it; a frame gives 16 or 40 results.
// Input ready drops only while the two-entry frame queue is full.
// Reset (rst, synchronous) clears the window, counters and pipeline; interval returns to 66.
`timescale 1ns / 1ps
`default_nettype none
module sbus_decode_and_telemetry_reframe_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // rx_byte
  input  wire         s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // channel_index, raw_value, pulse_width, failsafe, tx_byte
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  input  wire         cfg_wen,
  input  wire  [15:0] cfg_wdata       // frame_interval_ms
);
  import sbdtr_pkg::*;

  sbdtr_job_t f_job, q_head;
  logic       f_push, q_full, q_pop, q_nempty;

  sbdtr_front u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_tick  (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .cfg_wen, .cfg_wdata,
    .job_valid(f_push),
    .job_full (q_full),
    .job      (f_job)
  );

  sbdtr_queue u_queue (
    .clk, .rst,
    .push     (f_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_nempty),
    .head     (q_head)
  );

  sbdtr_back u_back (
    .clk, .rst,
    .job_valid(q_nempty),
    .job      (q_head),
    .job_pop  (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_kind (m_axis_tuser),
    .out_last (m_axis_tlast),
    .out_data (m_axis_tdata)
  );

endmodule
`default_nettype wire
